FILE: rtl/core/orbital_frame_impulse_assert.svh
// Assertion macros for the top-level RTL file of the orbital frame impulse block.
// In synthesis builds every macro expands to nothing.
`ifndef ORBITAL_FRAME_IMPULSE_ASSERT_SVH
`define ORBITAL_FRAME_IMPULSE_ASSERT_SVH
`ifndef SYNTH
`define OFI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ofi assertion failed");
`define OFI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ofi assertion failed");
`else
`define OFI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OFI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/ofi_pkg.sv
package ofi_pkg;

    localparam int UNIT_FRAC_BITS_DEF = 30;
    localparam int ISQRT_STAGES = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BURN_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_V_MAG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_DIR_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_DIR_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_DIR_Z   = 3'd5;

    localparam logic [2:0] MODE_PROGRADE    = 3'd0;
    localparam logic [2:0] MODE_RETROGRADE  = 3'd1;
    localparam logic [2:0] MODE_NORMAL      = 3'd2;
    localparam logic [2:0] MODE_ANTI_NORMAL = 3'd3;
    localparam logic [2:0] MODE_RADIAL_OUT  = 3'd4;
    localparam logic [2:0] MODE_RADIAL_IN   = 3'd5;
    localparam logic [2:0] MODE_CUSTOM      = 3'd6;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_ZERO_STATE  = 2'd1;
    localparam logic [1:0] ST_ZERO_H      = 2'd2;
    localparam logic [1:0] ST_ZERO_CUSTOM = 2'd3;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // Per-word control and pass-through data that travels beside the math.
    typedef struct packed {
        logic [2:0][31:0] vel;
        logic [2:0]       neg;
        logic             flip;
        logic             apply;
        logic [1:0]       status;
    } side_t;

    typedef struct packed {
        logic             burn_enable;
        logic [2:0]       direction_mode;
        logic [30:0]      delta_v_mag;
        logic [2:0][15:0] custom_dir;
    } cfg_t;

endpackage

FILE: rtl/core/ofi_cross.sv
module ofi_cross (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2:0][31:0] pos,
    input  logic [2:0][31:0] vel,
    output logic             out_valid,
    output logic [2:0][64:0] h_diff,
    output logic [2:0][31:0] pos_out,
    output logic [2:0][31:0] vel_out
);
    logic signed [31:0] ps [3];
    logic signed [31:0] vs [3];
    logic signed [63:0] pa_next [3];
    logic signed [63:0] pb_next [3];
    logic [2:0][63:0]   pa_reg;
    logic [2:0][63:0]   pb_reg;
    logic [2:0][64:0]   diff_next;
    logic [2:0][64:0]   diff_reg;
    logic [2:0][31:0]   pos1_reg, vel1_reg, pos2_reg, vel2_reg;
    logic               valid1_reg, valid2_reg;

    // Cross product terms of r x v; each pair is registered and then subtracted.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ps[i] = $signed(pos[i]);
            vs[i] = $signed(vel[i]);
        end
        pa_next[0] = ps[1] * vs[2];
        pb_next[0] = ps[2] * vs[1];
        pa_next[1] = ps[2] * vs[0];
        pb_next[1] = ps[0] * vs[2];
        pa_next[2] = ps[0] * vs[1];
        pb_next[2] = ps[1] * vs[0];
        for (int i = 0; i < 3; i++) begin
            diff_next[i] = {pa_reg[i][63], pa_reg[i]} - {pb_reg[i][63], pb_reg[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pa_reg[i] <= pa_next[i];
                pb_reg[i] <= pb_next[i];
            end
            pos1_reg <= pos;
            vel1_reg <= vel;
            diff_reg <= diff_next;
            pos2_reg <= pos1_reg;
            vel2_reg <= vel1_reg;
        end
    end

    assign out_valid = valid2_reg;
    assign h_diff    = diff_reg;
    assign pos_out   = pos2_reg;
    assign vel_out   = vel2_reg;

endmodule

FILE: rtl/core/ofi_prep.sv
module ofi_prep (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  ofi_pkg::cfg_t    cfg,
    input  logic [2:0][64:0] h_diff,
    input  logic [2:0][31:0] pos_in,
    input  logic [2:0][31:0] vel_in,
    output logic             out_valid,
    output logic [2:0][30:0] a_out,
    output logic [63:0]      sum_out,
    output ofi_pkg::side_t   side_out
);
    logic             r_zero, v_zero, h_zero, c_zero;
    logic [2:0]       mode;
    logic [2:0][64:0] h_abs;
    logic [2:0][31:0] p_abs, v_abs;
    logic [2:0][15:0] c_abs;
    ofi_pkg::side_t   side_next;
    logic [2:0][63:0] dmag_next;

    logic [2:0][63:0] dmag3_reg, dmag4_reg;
    logic [63:0]      or_all;
    logic [5:0]       msb;
    logic [5:0]       sh_next, sh_reg;
    logic [2:0][63:0] shifted;
    logic [2:0][30:0] a5_reg, a6_reg, a7_reg;
    logic [2:0][61:0] sq_next, sq_reg;
    logic [63:0]      sum_next, sum_reg;
    ofi_pkg::side_t   side3_reg, side4_reg, side5_reg, side6_reg, side7_reg;
    logic             valid3_reg, valid4_reg, valid5_reg, valid6_reg, valid7_reg;

    // Stage 3: magnitudes, exception checks and direction select.
    always_comb begin
        r_zero = (pos_in == '0);
        v_zero = (vel_in == '0);
        h_zero = (h_diff == '0);
        c_zero = (cfg.custom_dir == '0);
        mode   = cfg.direction_mode;
        for (int i = 0; i < 3; i++) begin
            h_abs[i] = h_diff[i][64] ? (65'd0 - h_diff[i]) : h_diff[i];
            p_abs[i] = pos_in[i][31] ? (32'd0 - pos_in[i]) : pos_in[i];
            v_abs[i] = vel_in[i][31] ? (32'd0 - vel_in[i]) : vel_in[i];
            c_abs[i] = cfg.custom_dir[i][15] ? (16'd0 - cfg.custom_dir[i]) : cfg.custom_dir[i];
        end
        side_next.vel    = vel_in;
        side_next.flip   = mode[0] && (mode < ofi_pkg::MODE_CUSTOM);
        side_next.status = ofi_pkg::ST_OK;
        side_next.apply  = 1'b0;
        side_next.neg    = '0;
        dmag_next        = '0;
        case (mode)
            ofi_pkg::MODE_PROGRADE, ofi_pkg::MODE_RETROGRADE: begin
                for (int i = 0; i < 3; i++) begin
                    side_next.neg[i] = vel_in[i][31];
                    dmag_next[i]     = 64'(v_abs[i]);
                end
            end
            ofi_pkg::MODE_NORMAL, ofi_pkg::MODE_ANTI_NORMAL: begin
                for (int i = 0; i < 3; i++) begin
                    side_next.neg[i] = h_diff[i][64];
                    dmag_next[i]     = h_abs[i][63:0];
                end
            end
            ofi_pkg::MODE_RADIAL_OUT, ofi_pkg::MODE_RADIAL_IN: begin
                for (int i = 0; i < 3; i++) begin
                    side_next.neg[i] = pos_in[i][31];
                    dmag_next[i]     = 64'(p_abs[i]);
                end
            end
            ofi_pkg::MODE_CUSTOM: begin
                for (int i = 0; i < 3; i++) begin
                    side_next.neg[i] = cfg.custom_dir[i][15];
                    dmag_next[i]     = 64'(c_abs[i]);
                end
            end
            default: begin
            end
        endcase
        if (cfg.burn_enable) begin
            if (r_zero || v_zero) begin
                side_next.status = ofi_pkg::ST_ZERO_STATE;
            end else if (h_zero) begin
                side_next.status = ofi_pkg::ST_ZERO_H;
            end else if (mode == ofi_pkg::MODE_CUSTOM) begin
                if (c_zero) begin
                    side_next.status = ofi_pkg::ST_ZERO_CUSTOM;
                end else begin
                    side_next.apply = 1'b1;
                end
            end else if (mode < ofi_pkg::MODE_CUSTOM) begin
                side_next.apply = 1'b1;
            end
        end
    end

    // Stage 4: count for the common right shift that brings every component below 2^31.
    always_comb begin
        or_all = dmag3_reg[0] | dmag3_reg[1] | dmag3_reg[2];
        msb    = '0;
        for (int i = 0; i < 64; i++) begin
            if (or_all[i]) begin
                msb = 6'(i);
            end
        end
        sh_next = (msb >= 6'd31) ? (msb - 6'd30) : 6'd0;
    end

    // Stages 5 to 7: shift, squares, sum of squares.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shifted[i] = dmag4_reg[i] >> sh_reg;
            sq_next[i] = a5_reg[i] * a5_reg[i];
        end
        sum_next = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
            valid6_reg <= 1'b0;
            valid7_reg <= 1'b0;
        end else if (en) begin
            valid3_reg <= in_valid;
            valid4_reg <= valid3_reg;
            valid5_reg <= valid4_reg;
            valid6_reg <= valid5_reg;
            valid7_reg <= valid6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side3_reg <= side_next;
            dmag3_reg <= dmag_next;
            side4_reg <= side3_reg;
            dmag4_reg <= dmag3_reg;
            sh_reg    <= sh_next;
            side5_reg <= side4_reg;
            for (int i = 0; i < 3; i++) begin
                a5_reg[i] <= shifted[i][30:0];
            end
            side6_reg <= side5_reg;
            a6_reg    <= a5_reg;
            sq_reg    <= sq_next;
            side7_reg <= side6_reg;
            a7_reg    <= a6_reg;
            sum_reg   <= sum_next;
        end
    end

    assign out_valid = valid7_reg;
    assign a_out     = a7_reg;
    assign sum_out   = sum_reg;
    assign side_out  = side7_reg;

endmodule

FILE: rtl/core/ofi_isqrt.sv
module ofi_isqrt (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [63:0]      sum,
    input  logic [2:0][30:0] a_in,
    input  ofi_pkg::side_t   side_in,
    output logic             out_valid,
    output logic [31:0]      root,
    output logic [2:0][30:0] a_out,
    output ofi_pkg::side_t   side_out
);
    localparam int NS = ofi_pkg::ISQRT_STAGES;
    localparam int TOP_BIT = 2 * NS - 2;

    logic [63:0]      x_reg    [NS];
    logic [63:0]      res_reg  [NS];
    logic [2:0][30:0] a_reg    [NS];
    ofi_pkg::side_t   side_reg [NS];
    logic             valid_reg [NS];

    // One result bit per stage, restoring square root.
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [63:0]      x_cur, res_cur, bit_k, trial, x_next, res_next;
        logic [2:0][30:0] a_cur;
        ofi_pkg::side_t   side_cur;
        logic             valid_cur;

        if (k == 0) begin : g_first
            assign x_cur     = sum;
            assign res_cur   = '0;
            assign a_cur     = a_in;
            assign side_cur  = side_in;
            assign valid_cur = in_valid;
        end else begin : g_rest
            assign x_cur     = x_reg[k-1];
            assign res_cur   = res_reg[k-1];
            assign a_cur     = a_reg[k-1];
            assign side_cur  = side_reg[k-1];
            assign valid_cur = valid_reg[k-1];
        end

        assign bit_k = 64'd1 << (TOP_BIT - 2 * k);
        assign trial = res_cur + bit_k;

        always_comb begin
            if (x_cur >= trial) begin
                x_next   = x_cur - trial;
                res_next = (res_cur >> 1) + bit_k;
            end else begin
                x_next   = x_cur;
                res_next = res_cur >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= x_next;
                res_reg[k]  <= res_next;
                a_reg[k]    <= a_cur;
                side_reg[k] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign root      = res_reg[NS-1][31:0];
    assign a_out     = a_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

FILE: rtl/core/ofi_unit.sv
module ofi_unit #(
    parameter int UNIT_FRAC_BITS = ofi_pkg::UNIT_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [31:0]                root,
    input  logic [2:0][30:0]           a_in,
    input  ofi_pkg::side_t             side_in,
    output logic                       out_valid,
    output logic [2:0][UNIT_FRAC_BITS:0] u_out,
    output ofi_pkg::side_t             side_out
);
    localparam int QW = UNIT_FRAC_BITS + 1;
    localparam int NU = UNIT_FRAC_BITS + 2;

    logic [2:0][QW-1:0] q_reg    [NU];
    logic [2:0][31:0]   r_reg    [NU-1];
    logic [31:0]        n_reg    [NU-1];
    ofi_pkg::side_t     side_reg [NU];
    logic               valid_reg [NU];

    // First stage takes the integer quotient (0 or 1), then one fraction bit
    // per stage, and the last stage rounds half up on the next remainder bit.
    for (genvar k = 0; k < NU; k++) begin : g_stage
        logic [2:0][QW-1:0] q_next;
        ofi_pkg::side_t     side_cur;
        logic               valid_cur;

        if (k == 0) begin : g_first
            logic [31:0]      nn;
            logic [2:0]       ge;
            logic [2:0][31:0] r_next;

            assign side_cur  = side_in;
            assign valid_cur = in_valid;
            assign nn = (root == '0) ? 32'd1 : root;

            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    ge[i]     = {1'b0, a_in[i]} >= nn;
                    r_next[i] = ge[i] ? ({1'b0, a_in[i]} - nn) : {1'b0, a_in[i]};
                    q_next[i] = QW'(ge[i]);
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k] <= r_next;
                    n_reg[k] <= nn;
                end
            end
        end else if (k < NU - 1) begin : g_mid
            logic [2:0]       ge;
            logic [2:0][32:0] r2;
            logic [2:0][31:0] r_next;

            assign side_cur  = side_reg[k-1];
            assign valid_cur = valid_reg[k-1];

            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    r2[i]     = {r_reg[k-1][i], 1'b0};
                    ge[i]     = r2[i] >= {1'b0, n_reg[k-1]};
                    r_next[i] = ge[i] ? 32'(r2[i] - {1'b0, n_reg[k-1]}) : r2[i][31:0];
                    q_next[i] = {q_reg[k-1][i][QW-2:0], ge[i]};
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k] <= r_next;
                    n_reg[k] <= n_reg[k-1];
                end
            end
        end else begin : g_round
            logic [2:0] ge;

            assign side_cur  = side_reg[k-1];
            assign valid_cur = valid_reg[k-1];

            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    ge[i]     = {r_reg[k-1][i], 1'b0} >= {1'b0, n_reg[k-1]};
                    q_next[i] = q_reg[k-1][i] + QW'(ge[i]);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]    <= q_next;
                side_reg[k] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[NU-1];
    assign u_out     = q_reg[NU-1];
    assign side_out  = side_reg[NU-1];

endmodule

FILE: rtl/core/ofi_apply.sv
module ofi_apply #(
    parameter int UNIT_FRAC_BITS = ofi_pkg::UNIT_FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [2:0][UNIT_FRAC_BITS:0] u_in,
    input  logic [30:0]                  delta_v_mag,
    input  ofi_pkg::side_t               side_in,
    output logic                         out_valid,
    output logic [2:0][31:0]             new_vel,
    output logic [1:0]                   status_code,
    output logic                         saturated
);
    localparam int UW   = UNIT_FRAC_BITS + 1;
    localparam int UH_W = (UW > 32) ? (UW - 32) : 1;
    localparam int UE_W = 32 + UH_W;
    localparam int PW   = UE_W + 32;

    logic [2:0][UE_W-1:0]   ue;
    logic [2:0][62:0]       lo_next, lo_reg;
    logic [2:0][UH_W+30:0]  mid_next, mid_reg;
    logic [2:0][PW-1:0]     total;
    logic [2:0][31:0]       dv_next, dv_reg;
    logic [2:0]             neg;
    logic [2:0][33:0]       s34;
    logic [2:0][31:0]       nv_next, nv_reg;
    logic [2:0]             clip;
    logic                   sat_next, sat_reg;
    logic [1:0]             status_reg;
    ofi_pkg::side_t         side_a_reg, side_b_reg;
    logic                   valid_a_reg, valid_b_reg, valid_c_reg;

    // Unit component times delta-v, split into a low 32-bit partial product
    // and a narrow high one, then rounded half up at the fraction point.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ue[i]       = UE_W'(u_in[i]);
            lo_next[i]  = ue[i][31:0] * delta_v_mag;
            mid_next[i] = ue[i][UE_W-1:32] * delta_v_mag;
            total[i]    = PW'(lo_reg[i]) + (PW'(mid_reg[i]) << 32)
                        + (PW'(1) << (UNIT_FRAC_BITS - 1));
            dv_next[i]  = total[i][UNIT_FRAC_BITS +: 32];
        end
    end

    // Signed add to the velocity with clipping to the 32-bit range.
    always_comb begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = side_b_reg.neg[i] ^ side_b_reg.flip;
            s34[i] = {{2{side_b_reg.vel[i][31]}}, side_b_reg.vel[i]}
                   + (neg[i] ? (34'd0 - {2'b00, dv_reg[i]}) : {2'b00, dv_reg[i]});
            clip[i] = 1'b0;
            if (!side_b_reg.apply) begin
                nv_next[i] = side_b_reg.vel[i];
            end else if (!s34[i][33] && (s34[i][32:31] != 2'b00)) begin
                nv_next[i] = ofi_pkg::SAT_POS;
                clip[i]    = 1'b1;
            end else if (s34[i][33] && (s34[i][32:31] != 2'b11)) begin
                nv_next[i] = ofi_pkg::SAT_NEG;
                clip[i]    = 1'b1;
            end else begin
                nv_next[i] = s34[i][31:0];
            end
            sat_next = sat_next | clip[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end else if (en) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg     <= lo_next;
            mid_reg    <= mid_next;
            side_a_reg <= side_in;
            dv_reg     <= dv_next;
            side_b_reg <= side_a_reg;
            nv_reg     <= nv_next;
            sat_reg    <= sat_next;
            status_reg <= side_b_reg.status;
        end
    end

    assign out_valid   = valid_c_reg;
    assign new_vel     = nv_reg;
    assign status_code = status_reg;
    assign saturated   = sat_reg;

endmodule

FILE: rtl/core/orbital_frame_impulse.sv
// Throughput: one word per cycle; the whole pipeline advances whenever the output is free.
// The slowest chain is the 32-stage square root plus one divider stage per fraction bit.
// Reset (aresetn low at a clock edge) empties the pipeline by clearing every valid bit and
// clears the configuration registers to 0; data registers keep their contents.
`include "orbital_frame_impulse_assert.svh"

module orbital_frame_impulse #(
    parameter int UNIT_FRAC_BITS = ofi_pkg::UNIT_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ofi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ofi_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [31:0]              s_pos_x,
    input  logic signed [31:0]              s_pos_y,
    input  logic signed [31:0]              s_pos_z,
    input  logic signed [31:0]              s_vel_x,
    input  logic signed [31:0]              s_vel_y,
    input  logic signed [31:0]              s_vel_z,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_new_vel_x,
    output logic signed [31:0]              m_new_vel_y,
    output logic signed [31:0]              m_new_vel_z,
    output logic [1:0]                      m_status_code,
    output logic                            m_saturated
);
    // The pipeline moves as one: every stage register, including the output
    // register, loads when the output is empty or being taken this cycle.
    // Valid bits travel with the data, so bubbles carry no result.
    logic en;

    ofi_pkg::cfg_t cfg_reg;

    logic [2:0][31:0] pos, vel;

    logic             cross_valid;
    logic [2:0][64:0] h_diff;
    logic [2:0][31:0] cross_pos, cross_vel;

    logic             prep_valid;
    logic [2:0][30:0] prep_a;
    logic [63:0]      prep_sum;
    ofi_pkg::side_t   prep_side;

    logic             sqrt_valid;
    logic [31:0]      sqrt_root;
    logic [2:0][30:0] sqrt_a;
    ofi_pkg::side_t   sqrt_side;

    logic                         unit_valid;
    logic [2:0][UNIT_FRAC_BITS:0] unit_u;
    ofi_pkg::side_t               unit_side;

    logic [2:0][31:0] new_vel;

    assign en        = m_ready || !m_valid;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    assign pos = {s_pos_z, s_pos_y, s_pos_x};
    assign vel = {s_vel_z, s_vel_y, s_vel_x};

    // Configuration registers. Writes to indexes past the register list are
    // accepted and dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ofi_pkg::REG_BURN_ENABLE:    cfg_reg.burn_enable    <= cfg_data[0];
                ofi_pkg::REG_DIRECTION_MODE: cfg_reg.direction_mode <= cfg_data[2:0];
                ofi_pkg::REG_DELTA_V_MAG:    cfg_reg.delta_v_mag    <= cfg_data[30:0];
                ofi_pkg::REG_CUSTOM_DIR_X:   cfg_reg.custom_dir[0]  <= cfg_data[15:0];
                ofi_pkg::REG_CUSTOM_DIR_Y:   cfg_reg.custom_dir[1]  <= cfg_data[15:0];
                ofi_pkg::REG_CUSTOM_DIR_Z:   cfg_reg.custom_dir[2]  <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Two stages: the six cross-product multiplies, then their differences.
    ofi_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .pos       (pos),
        .vel       (vel),
        .out_valid (cross_valid),
        .h_diff    (h_diff),
        .pos_out   (cross_pos),
        .vel_out   (cross_vel)
    );

    // Five stages: exception checks and direction select, block shift count,
    // shift, squares, and sum of squares.
    ofi_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cross_valid),
        .cfg       (cfg_reg),
        .h_diff    (h_diff),
        .pos_in    (cross_pos),
        .vel_in    (cross_vel),
        .out_valid (prep_valid),
        .a_out     (prep_a),
        .sum_out   (prep_sum),
        .side_out  (prep_side)
    );

    // Integer square root of the sum of squares, one result bit per stage.
    ofi_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_valid),
        .sum       (prep_sum),
        .a_in      (prep_a),
        .side_in   (prep_side),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .a_out     (sqrt_a),
        .side_out  (sqrt_side)
    );

    // Three lanes of restoring division give the unit vector magnitudes.
    ofi_unit #(
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sqrt_valid),
        .root      (sqrt_root),
        .a_in      (sqrt_a),
        .side_in   (sqrt_side),
        .out_valid (unit_valid),
        .u_out     (unit_u),
        .side_out  (unit_side)
    );

    // Three stages: partial products, rounding, then signed add with clipping
    // into the output register. Words with no burn pass their velocity here.
    ofi_apply #(
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_apply (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (unit_valid),
        .u_in        (unit_u),
        .delta_v_mag (cfg_reg.delta_v_mag),
        .side_in     (unit_side),
        .out_valid   (m_valid),
        .new_vel     (new_vel),
        .status_code (m_status_code),
        .saturated   (m_saturated)
    );

    assign m_new_vel_x = new_vel[0];
    assign m_new_vel_y = new_vel[1];
    assign m_new_vel_z = new_vel[2];

    // A word that reports an exception never carries a clipped velocity.
    `OFI_ASSERT_IMP(a_status_no_sat, aclk, aresetn,
        m_valid && (m_status_code != ofi_pkg::ST_OK), !m_saturated)
    // A clipped word holds at least one component at a range limit.
    `OFI_ASSERT_IMP(a_sat_at_limit, aclk, aresetn, m_valid && m_saturated,
        (m_new_vel_x == ofi_pkg::SAT_POS) || (m_new_vel_x == ofi_pkg::SAT_NEG) ||
        (m_new_vel_y == ofi_pkg::SAT_POS) || (m_new_vel_y == ofi_pkg::SAT_NEG) ||
        (m_new_vel_z == ofi_pkg::SAT_POS) || (m_new_vel_z == ofi_pkg::SAT_NEG))
    // A held result freezes the whole pipeline, input side included.
    `OFI_ASSERT_IMP(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)
    // A write to the enable register lands on the next edge.
    `OFI_ASSERT_NEXT(a_cfg_enable_write, aclk, aresetn,
        cfg_valid && cfg_ready && (cfg_index == ofi_pkg::REG_BURN_ENABLE),
        cfg_reg.burn_enable == $past(cfg_data[0]))

endmodule

FILE: tb/ofi_burn_checker.sv
`timescale 1ns / 1ps

module ofi_burn_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ofi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ofi_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic signed [31:0]              s_pos_x,
    input  logic signed [31:0]              s_pos_y,
    input  logic signed [31:0]              s_pos_z,
    input  logic signed [31:0]              s_vel_x,
    input  logic signed [31:0]              s_vel_y,
    input  logic signed [31:0]              s_vel_z,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic signed [31:0]              m_new_vel_x,
    input  logic signed [31:0]              m_new_vel_y,
    input  logic signed [31:0]              m_new_vel_z,
    input  logic [1:0]                      m_status_code,
    input  logic                            m_saturated,
    output int                              mismatches,
    output int                              pending,
    output int                              words_checked
);

    localparam int FRAC = ofi_pkg::UNIT_FRAC_BITS_DEF;

    typedef struct {
        logic signed [31:0] vel [3];
        logic [1:0]         status;
        logic               sat;
    } burn_result_t;

    burn_result_t burn_expected[$];

    logic             sh_enable;
    logic [2:0]       sh_mode;
    logic [30:0]      sh_dv;
    logic [15:0]      sh_custom [3];

    function automatic bit [63:0] root_floor(bit [63:0] x);
        bit [63:0] res = 0;
        bit [63:0] b = 64'h1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Round-half-up of a * 2^FRAC / n by long division.
    function automatic bit [63:0] unit_component(bit [63:0] a, bit [63:0] n);
        bit [63:0] q = a / n;
        bit [63:0] r = a % n;
        for (int i = 0; i < FRAC; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= n) begin
                r -= n;
                q[0] = 1'b1;
            end
        end
        r <<= 1;
        if (r >= n) q++;
        return q;
    endfunction

    function automatic burn_result_t predict_burn(logic signed [31:0] p [3],
                                                  logic signed [31:0] v [3]);
        burn_result_t       res;
        logic signed [65:0] hs [3];
        bit [63:0]          dmag [3];
        bit                 dneg [3];
        bit [63:0]          a [3];
        bit [63:0]          n2;
        bit [63:0]          n;
        bit [127:0]         prod;
        longint             dv;
        longint             sum;
        int                 sh;
        bit                 apply;
        bit                 flip;
        bit                 r_zero;
        bit                 v_zero;
        res.status = ofi_pkg::ST_OK;
        res.sat = 1'b0;
        apply = 1'b0;
        flip = 1'b0;
        for (int i = 0; i < 3; i++) res.vel[i] = v[i];
        hs[0] = 66'(longint'(p[1]) * v[2]) - 66'(longint'(p[2]) * v[1]);
        hs[1] = 66'(longint'(p[2]) * v[0]) - 66'(longint'(p[0]) * v[2]);
        hs[2] = 66'(longint'(p[0]) * v[1]) - 66'(longint'(p[1]) * v[0]);
        r_zero = (p[0] == 0) && (p[1] == 0) && (p[2] == 0);
        v_zero = (v[0] == 0) && (v[1] == 0) && (v[2] == 0);
        if (sh_enable) begin
            if (r_zero || v_zero) begin
                res.status = ofi_pkg::ST_ZERO_STATE;
            end else if (hs[0] == 0 && hs[1] == 0 && hs[2] == 0) begin
                res.status = ofi_pkg::ST_ZERO_H;
            end else begin
                flip = sh_mode[0] && (sh_mode < ofi_pkg::MODE_CUSTOM);
                for (int i = 0; i < 3; i++) begin
                    case (sh_mode)
                        ofi_pkg::MODE_PROGRADE, ofi_pkg::MODE_RETROGRADE: begin
                            dneg[i] = v[i] < 0;
                            dmag[i] = 64'(v[i] < 0 ? -longint'(v[i]) : longint'(v[i]));
                        end
                        ofi_pkg::MODE_NORMAL, ofi_pkg::MODE_ANTI_NORMAL: begin
                            dneg[i] = hs[i] < 0;
                            dmag[i] = 64'(hs[i] < 0 ? -hs[i] : hs[i]);
                        end
                        ofi_pkg::MODE_RADIAL_OUT, ofi_pkg::MODE_RADIAL_IN: begin
                            dneg[i] = p[i] < 0;
                            dmag[i] = 64'(p[i] < 0 ? -longint'(p[i]) : longint'(p[i]));
                        end
                        default: begin
                            dneg[i] = sh_custom[i][15];
                            dmag[i] = 64'(sh_custom[i][15] ? -longint'($signed(sh_custom[i]))
                                                           : longint'($signed(sh_custom[i])));
                        end
                    endcase
                end
                if (sh_mode == ofi_pkg::MODE_CUSTOM) begin
                    if (dmag[0] == 0 && dmag[1] == 0 && dmag[2] == 0)
                        res.status = ofi_pkg::ST_ZERO_CUSTOM;
                    else
                        apply = 1'b1;
                end else if (sh_mode < ofi_pkg::MODE_CUSTOM) begin
                    apply = 1'b1;
                end
            end
        end
        if (apply) begin
            // Common right shift until every component fits in 31 bits.
            sh = 0;
            while ((dmag[0] >> sh) >= 64'h8000_0000 || (dmag[1] >> sh) >= 64'h8000_0000 ||
                   (dmag[2] >> sh) >= 64'h8000_0000)
                sh++;
            n2 = 0;
            for (int i = 0; i < 3; i++) begin
                a[i] = dmag[i] >> sh;
                n2 += a[i] * a[i];
            end
            n = root_floor(n2);
            if (n == 0) n = 1;
            for (int i = 0; i < 3; i++) begin
                prod = 128'(unit_component(a[i], n)) * 128'(sh_dv);
                prod = (prod + (128'h1 << (FRAC - 1))) >> FRAC;
                dv = longint'(prod[63:0]);
                if (dneg[i] != flip) dv = -dv;
                sum = longint'(v[i]) + dv;
                if (sum > 64'sd2147483647) begin
                    sum = 64'sd2147483647;
                    res.sat = 1'b1;
                end
                if (sum < -64'sd2147483648) begin
                    sum = -64'sd2147483648;
                    res.sat = 1'b1;
                end
                res.vel[i] = sum[31:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on word %0d: %s got %0d expected %0d",
                 words_checked, what, got, want);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
        pending = 0;
        words_checked = 0;
    end

    always @(posedge aclk) begin
        burn_result_t        want;
        logic signed [31:0]  p [3];
        logic signed [31:0]  v [3];
        if (!aresetn) begin
            sh_enable <= 1'b0;
            sh_mode <= ofi_pkg::MODE_PROGRADE;
            sh_dv <= '0;
            for (int i = 0; i < 3; i++) sh_custom[i] <= '0;
            burn_expected.delete();
        end else begin
            // The block is idle during register writes, so updating the shadow copy
            // here never affects a word already in flight.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ofi_pkg::REG_BURN_ENABLE:    sh_enable <= cfg_data[0];
                    ofi_pkg::REG_DIRECTION_MODE: sh_mode <= cfg_data[2:0];
                    ofi_pkg::REG_DELTA_V_MAG:    sh_dv <= cfg_data[30:0];
                    ofi_pkg::REG_CUSTOM_DIR_X:   sh_custom[0] <= cfg_data[15:0];
                    ofi_pkg::REG_CUSTOM_DIR_Y:   sh_custom[1] <= cfg_data[15:0];
                    ofi_pkg::REG_CUSTOM_DIR_Z:   sh_custom[2] <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                p[0] = s_pos_x; p[1] = s_pos_y; p[2] = s_pos_z;
                v[0] = s_vel_x; v[1] = s_vel_y; v[2] = s_vel_z;
                burn_expected.push_back(predict_burn(p, v));
            end
            if (m_valid && m_ready) begin
                if (burn_expected.size() == 0) begin
                    report_mismatch("result words outstanding", 1, 0);
                end else begin
                    want = burn_expected.pop_front();
                    if (m_new_vel_x !== want.vel[0])
                        report_mismatch("new_vel_x", m_new_vel_x, want.vel[0]);
                    if (m_new_vel_y !== want.vel[1])
                        report_mismatch("new_vel_y", m_new_vel_y, want.vel[1]);
                    if (m_new_vel_z !== want.vel[2])
                        report_mismatch("new_vel_z", m_new_vel_z, want.vel[2]);
                    if (m_status_code !== want.status)
                        report_mismatch("status_code", m_status_code, want.status);
                    if (m_saturated !== want.sat)
                        report_mismatch("saturated", m_saturated, want.sat);
                end
                words_checked++;
            end
        end
        pending = burn_expected.size();
    end

endmodule

FILE: tb/tb_orbital_frame_impulse.sv
`timescale 1ns / 1ps

module tb_orbital_frame_impulse;

    // Random phases after the directed part; each has its own register setting.
    localparam int NUM_PHASES = 14;
    localparam int WORDS_PER_PHASE = 125;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ofi_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ofi_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic signed [31:0]             s_pos_x, s_pos_y, s_pos_z;
    logic signed [31:0]             s_vel_x, s_vel_y, s_vel_z;
    logic                           m_valid;
    logic                           m_ready;
    logic signed [31:0]             m_new_vel_x, m_new_vel_y, m_new_vel_z;
    logic [1:0]                     m_status_code;
    logic                           m_saturated;

    int mismatches;
    int pending;
    int words_checked;
    int words_sent;
    int reg_writes;
    int burst_left;
    bit s_hold;
    bit cfg_hold;

    orbital_frame_impulse dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_vel_x(s_vel_x), .s_vel_y(s_vel_y), .s_vel_z(s_vel_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_vel_x(m_new_vel_x), .m_new_vel_y(m_new_vel_y),
        .m_new_vel_z(m_new_vel_z), .m_status_code(m_status_code),
        .m_saturated(m_saturated)
    );

    // The checker sits beside the block, watches all three channels and keeps
    // its own copy of the registers to predict every result word.
    ofi_burn_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_vel_x(s_vel_x), .s_vel_y(s_vel_y), .s_vel_z(s_vel_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_vel_x(m_new_vel_x), .m_new_vel_y(m_new_vel_y),
        .m_new_vel_z(m_new_vel_z), .m_status_code(m_status_code),
        .m_saturated(m_saturated),
        .mismatches(mismatches), .pending(pending), .words_checked(words_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // A hard ceiling on simulated time, far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("timeout with %0d result words outstanding", pending);
        $display("FAIL");
        $finish;
    end

    // The receiver switches among three stall styles: always ready, coin flips,
    // or a periodic window of stalls, so back pressure lands on every pipeline phase.
    int rx_cycle;
    int rx_style;
    int rx_period;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_cycle <= 0;
            rx_style <= 0;
            rx_period <= 4;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 63) begin
                rx_style <= $urandom_range(0, 2);
                rx_period <= $urandom_range(2, 9);
            end
            case (rx_style)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= (rx_cycle % rx_period) != 0;
            endcase
        end
    end

    // Sends one state word and holds it until accepted. The sender works in bursts;
    // between bursts valid drops for a random gap, sometimes none at all.
    task automatic send_state(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        int gap;
        s_valid <= 1'b1;
        s_hold = 1'b1;
        s_pos_x <= px; s_pos_y <= py; s_pos_z <= pz;
        s_vel_x <= vx; s_vel_y <= vy; s_vel_z <= vz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                s_hold = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Lowers valid and waits until every expected result word has come back.
    // Every input word produces a result, so an empty queue means the block is idle.
    task automatic drain_pipeline();
        if (s_hold) s_valid <= 1'b0;
        s_hold = 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    // Register writes back to back keep valid high; release_cfg drops it afterwards.
    task automatic write_reg(logic [ofi_pkg::CFG_IDX_W-1:0] idx,
                             logic [ofi_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_hold = 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        reg_writes++;
    endtask

    task automatic release_cfg();
        if (cfg_hold) cfg_valid <= 1'b0;
        cfg_hold = 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_burn(logic en, logic [2:0] mode, logic [30:0] dv,
                            logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
        drain_pipeline();
        // Upper bits beyond each field's width get random garbage to check masking.
        write_reg(ofi_pkg::REG_BURN_ENABLE, {31'($urandom), en});
        write_reg(ofi_pkg::REG_DIRECTION_MODE, {29'($urandom), mode});
        write_reg(ofi_pkg::REG_DELTA_V_MAG, {1'($urandom_range(0, 1)), dv});
        write_reg(ofi_pkg::REG_CUSTOM_DIR_X, {16'($urandom), cx});
        write_reg(ofi_pkg::REG_CUSTOM_DIR_Y, {16'($urandom), cy});
        write_reg(ofi_pkg::REG_CUSTOM_DIR_Z, {16'($urandom), cz});
        release_cfg();
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'h1;
            4: return 32'hFFFF_FFFF;
            default: return 32'h8000_0001;
        endcase
    endfunction

    // A component whose size spreads over the whole range, from tiny to full scale.
    function automatic logic [31:0] pick_component();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 1)) w = $signed(w) >>> $urandom_range(0, 30);
        return w;
    endfunction

    function automatic logic [15:0] pick_custom();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [30:0] pick_dv();
        case ($urandom_range(0, 4))
            0: return 31'h7FFF_FFFF;
            1: return 31'($urandom_range(0, 1));
            2: return 31'($urandom) >> $urandom_range(0, 30);
            default: return 31'($urandom);
        endcase
    endfunction

    // One random state word. Most are general states; a share hit the zero position,
    // zero velocity and parallel (no angular momentum) cases, and some use extremes.
    task automatic send_random_state();
        logic [31:0] p [3];
        logic [31:0] v [3];
        int          k;
        for (int i = 0; i < 3; i++) begin
            p[i] = pick_component();
            v[i] = pick_component();
        end
        case ($urandom_range(0, 11))
            0: for (int i = 0; i < 3; i++) p[i] = 0;
            1: for (int i = 0; i < 3; i++) v[i] = 0;
            2: begin
                k = $urandom_range(0, 200) - 100;
                if (k == 0) k = -1;
                for (int i = 0; i < 3; i++) begin
                    p[i] = 32'($signed(16'($urandom)));
                    v[i] = 32'($signed(p[i]) * k);
                end
            end
            3: for (int i = 0; i < 3; i++) begin
                p[i] = pick_extreme();
                v[i] = pick_extreme();
            end
            4: begin
                // Only one axis of each vector set.
                for (int i = 0; i < 3; i++) begin
                    p[i] = (i == 0) ? p[i] : 32'h0;
                    v[i] = (i == 1) ? v[i] : 32'h0;
                end
            end
            default: ;
        endcase
        send_state(p[0], p[1], p[2], v[0], v[1], v[2]);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_pos_x = '0; s_pos_y = '0; s_pos_z = '0;
        s_vel_x = '0; s_vel_y = '0; s_vel_z = '0;
        words_sent = 0;
        reg_writes = 0;
        burst_left = 0;
        s_hold = 1'b0;
        cfg_hold = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers at their reset values: the burn is off and velocity passes through.
        send_state(32'd7000000, 32'd0, 32'd0, 32'd0, 32'd7500000, 32'd0);
        send_state(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);

        // Prograde at the largest impulse: zero position, zero velocity, parallel
        // vectors, and a state near the top of the range that must saturate.
        set_burn(1'b1, ofi_pkg::MODE_PROGRADE, 31'h7FFF_FFFF, 16'h0, 16'h0, 16'h0);
        send_state(32'h0, 32'h0, 32'h0, 32'd100, 32'd200, 32'd300);
        send_state(32'd100, 32'd200, 32'd300, 32'h0, 32'h0, 32'h0);
        send_state(32'd100, 32'd200, 32'd300, 32'hFFFF_FF38, 32'hFFFF_FE70, 32'hFFFF_FDA8);
        send_state(32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);

        // Each remaining direction, including the unused mode code, on one state.
        for (int m = ofi_pkg::MODE_RETROGRADE; m <= 7; m++) begin
            if (m == ofi_pkg::MODE_CUSTOM) continue;
            set_burn(1'b1, 3'(m), 31'd123456789, 16'h0, 16'h0, 16'h0);
            send_state(32'd6771000, 32'hFFF0_0000, 32'd12345,
                       32'd1000, 32'd7650000, 32'hFFFF_0000);
        end

        // Custom direction: a zero vector, then the field extremes.
        set_burn(1'b1, ofi_pkg::MODE_CUSTOM, 31'd5000, 16'h0, 16'h0, 16'h0);
        send_state(32'd6771000, 32'd1, 32'd2, 32'd3, 32'd7650000, 32'd4);
        set_burn(1'b1, ofi_pkg::MODE_CUSTOM, 31'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'h0);
        send_state(32'd6771000, 32'd1, 32'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'd4);
        send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_burn($urandom_range(0, 9) != 0, 3'($urandom_range(0, 7)), pick_dv(),
                     pick_custom(), pick_custom(), pick_custom());
            for (int i = 0; i < WORDS_PER_PHASE; i++) send_random_state();
        end

        drain_pipeline();
        repeat (100) @(posedge aclk);

        $display("sent %0d state words, checked %0d result words, %0d register writes",
                 words_sent, words_checked, reg_writes);
        $display("covered all directions, the unused mode, zero and parallel states");
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ofi_pkg.sv
rtl/core/ofi_cross.sv
rtl/core/ofi_prep.sv
rtl/core/ofi_isqrt.sv
rtl/core/ofi_unit.sv
rtl/core/ofi_apply.sv
rtl/core/orbital_frame_impulse.sv
tb/ofi_burn_checker.sv
tb/tb_orbital_frame_impulse.sv
